// File: design/psfl_pkg.sv
// shared constants, codes and types of the page and slice free-list allocator
package psfl_pkg;

   parameter int FUNC_W      = 3;
   parameter int ADDR_W      = 32;
   parameter int WIDE_W      = 64;
   parameter int WORD_W      = 32;
   parameter int STATUS_W    = 2;
   parameter int ADDED_W     = 11;

   parameter int PAGE_SHIFT  = 12;
   parameter int SLICE_SHIFT = 10;
   parameter int PFN_W       = ADDR_W - PAGE_SHIFT;
   parameter int SLICE_NUM_W = ADDR_W - SLICE_SHIFT;
   parameter int PFN_EXT_W   = PFN_W + 1;
   parameter int CARVE_W     = PAGE_SHIFT - SLICE_SHIFT;

   parameter int PAGE_CAPACITY_DEF  = 1024;
   parameter int SLICE_CAPACITY_DEF = 1024;

   parameter logic [WORD_W-1:0] RTYPE_USABLE = 32'd1;
   parameter int REGION_IGNORE_BIT = 0;
   parameter int REGION_NONVOL_BIT = 1;
   parameter logic [ADDR_W-1:0] CUTOFF_RESET = 32'h0010_0000;
   parameter logic [ADDR_W:0]   ADDR_LIMIT   = 33'h1_0000_0000;
   parameter logic [ADDR_W:0]   PAGE_ROUND   = 33'((1 << PAGE_SHIFT) - 1);

   parameter logic [FUNC_W-1:0] FN_ADD_REGION  = 3'd0;
   parameter logic [FUNC_W-1:0] FN_PAGE_ALLOC  = 3'd1;
   parameter logic [FUNC_W-1:0] FN_PAGE_FREE   = 3'd2;
   parameter logic [FUNC_W-1:0] FN_SLICE_ALLOC = 3'd3;
   parameter logic [FUNC_W-1:0] FN_SLICE_FREE  = 3'd4;

   parameter logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   parameter logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   parameter logic [STATUS_W-1:0] STAT_SKIP  = 2'd2;
   parameter logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

   // page window of an add_region item, ready in the cycle after it is taken
   typedef struct packed {
      logic                 skip;
      logic [PFN_EXT_W-1:0] first;
      logic [PFN_EXT_W-1:0] last;
   } region_win_type;

endpackage

// File: design/psfl_if.sv
// request and response channel interfaces of the allocator

interface psfl_req_if;
   import psfl_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] addr;
   logic [WIDE_W-1:0] region_base;
   logic [WIDE_W-1:0] region_length;
   logic [WORD_W-1:0] region_type;
   logic [WORD_W-1:0] region_acpi;

   modport source (output valid, func, addr, region_base, region_length, region_type,
                   region_acpi, input ready);
   modport sink (input valid, func, addr, region_base, region_length, region_type,
                 region_acpi, output ready);
endinterface

interface psfl_rsp_if;
   import psfl_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_addr;
   logic [ADDED_W-1:0]  pages_added;

   modport source (output valid, status, result_addr, pages_added, input ready);
   modport sink (input valid, status, result_addr, pages_added, output ready);
endinterface

// File: design/psfl_ram.sv
// generic simple dual-port ram with registered read
module psfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/psfl_region.sv
// memory-map descriptor filter: clips and aligns a region to a page window
module psfl_region (
   input  logic                        clock,
   input  logic                        load,
   input  logic [psfl_pkg::WIDE_W-1:0] base,
   input  logic [psfl_pkg::WIDE_W-1:0] length,
   input  logic [psfl_pkg::WORD_W-1:0] rtype,
   input  logic [psfl_pkg::WORD_W-1:0] acpi,
   input  logic [psfl_pkg::ADDR_W-1:0] cutoff,
   output psfl_pkg::region_win_type    win
);
   import psfl_pkg::*;

   logic              rej_ff, rej_in;
   logic              low_ff, low_in;
   logic [ADDR_W:0]   end_ff, end_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W:0]   sum;
   logic [ADDR_W:0]   start_up;

   always_comb begin
      rej_in = !acpi[REGION_IGNORE_BIT] || acpi[REGION_NONVOL_BIT] ||
               (rtype != RTYPE_USABLE) || (base[WIDE_W-1:ADDR_W] != '0);
      sum = {1'b0, base[ADDR_W-1:0]} + {1'b0, length[ADDR_W-1:0]};
      // a length of 4 GB or more always reaches the limit
      if ((length[WIDE_W-1:ADDR_W] != '0) || (sum > ADDR_LIMIT)) begin
         end_in = ADDR_LIMIT;
      end else begin
         end_in = sum;
      end
      low_in   = end_in < {1'b0, cutoff};
      start_in = (base[ADDR_W-1:0] < cutoff) ? cutoff : base[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rej_ff   <= rej_in;
         low_ff   <= low_in;
         end_ff   <= end_in;
         start_ff <= start_in;
      end
   end

   always_comb begin
      start_up  = {1'b0, start_ff} + PAGE_ROUND;
      win.first = start_up[ADDR_W:PAGE_SHIFT];
      win.last  = end_ff[ADDR_W:PAGE_SHIFT];
      win.skip  = rej_ff || low_ff || (win.last <= win.first);
   end

endmodule

// File: design/page_slice_free_list_allocator.sv
// Page and slice free-list allocator. Free 4 KB page frames and free 1 KB slices are kept
// as two LIFO stacks, each in a one-write/one-read RAM with registered read; the stack
// pointers live in flip-flops and one item is worked on at a time. An item holds the block
// from acceptance until the cycle after its result is loaded into the output register.
// Page alloc, page free, slice free, unused codes and a slice alloc that finds a free
// slice (or no free page either) pass through S_PAGE_POP, S_SLICE_POP or S_DONE into the
// output register. A slice alloc on an empty slice stack otherwise pops a page and, in
// S_CARVE, writes three of its slices, one per cycle through the slice RAM write port.
// An add_region item passes S_REGION, then S_FILL, which pushes its pages through the
// single page RAM write port, then S_DONE; a skipped region skips S_FILL. While an earlier
// result still waits unaccepted in the output register, the finishing item waits with
// it. No clearing pass is needed after reset. The user writes low_cutoff (cutoff_ff)
// through csr_wr_en/csr_wr_data only while the block is idle; the block does not enforce it.
module page_slice_free_list_allocator #(
   parameter int PAGE_CAPACITY  = psfl_pkg::PAGE_CAPACITY_DEF,
   parameter int SLICE_CAPACITY = psfl_pkg::SLICE_CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   psfl_req_if.sink                    req,
   psfl_rsp_if.source                  rsp,
   input  logic                        csr_wr_en,
   input  logic [psfl_pkg::ADDR_W-1:0] csr_wr_data
);
   import psfl_pkg::*;

   localparam int PCW = $clog2(PAGE_CAPACITY + 1);
   localparam int PAW = $clog2(PAGE_CAPACITY);
   localparam int SCW = $clog2(SLICE_CAPACITY + 1);
   localparam int SAW = $clog2(SLICE_CAPACITY);
   localparam logic [SCW-1:0] CARVE_DONE = SCW'((1 << CARVE_W) - 1);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_REGION    = 7'b0000010,
      S_FILL      = 7'b0000100,
      S_PAGE_POP  = 7'b0001000,
      S_SLICE_POP = 7'b0010000,
      S_CARVE     = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [PCW-1:0]       pc_ff, pc_in, pc_dec;
   logic [SCW-1:0]       sc_ff, sc_in, sc_dec;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [ADDED_W-1:0]   added_ff, added_in;
   logic [PFN_EXT_W-1:0] frame_ff, frame_in;
   logic [ADDR_W-1:0]    cutoff_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [ADDED_W-1:0]   rsp_added_ff, rsp_added_in;

   logic                   pg_wr_en, pg_rd_en;
   logic [PAW-1:0]         pg_wr_addr, pg_rd_addr;
   logic [PFN_W-1:0]       pg_wr_data, pg_rd_data;
   logic                   sl_wr_en, sl_rd_en;
   logic [SAW-1:0]         sl_wr_addr, sl_rd_addr;
   logic [SLICE_NUM_W-1:0] sl_wr_data, sl_rd_data;

   logic           req_fire, slot_free, fin, pg_full, sl_full;
   logic [ADDR_W-1:0] fin_addr;
   region_win_type win;

   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign pc_dec    = pc_ff - PCW'(1);
   assign sc_dec    = sc_ff - SCW'(1);
   assign pg_full   = pc_ff == PCW'(PAGE_CAPACITY);
   assign sl_full   = sc_ff == SCW'(SLICE_CAPACITY);

   psfl_region u_region (
      .clock  (clock),
      .load   (req_fire && (req.func == FN_ADD_REGION)),
      .base   (req.region_base),
      .length (req.region_length),
      .rtype  (req.region_type),
      .acpi   (req.region_acpi),
      .cutoff (cutoff_ff),
      .win    (win)
   );

   psfl_ram #(.WIDTH(PFN_W), .DEPTH(PAGE_CAPACITY)) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_wr_en),
      .wr_addr (pg_wr_addr),
      .wr_data (pg_wr_data),
      .rd_en   (pg_rd_en),
      .rd_addr (pg_rd_addr),
      .rd_data (pg_rd_data)
   );

   psfl_ram #(.WIDTH(SLICE_NUM_W), .DEPTH(SLICE_CAPACITY)) u_slice_ram (
      .clock   (clock),
      .wr_en   (sl_wr_en),
      .wr_addr (sl_wr_addr),
      .wr_data (sl_wr_data),
      .rd_en   (sl_rd_en),
      .rd_addr (sl_rd_addr),
      .rd_data (sl_rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      sc_in     = sc_ff;
      status_in = status_ff;
      added_in  = added_ff;
      frame_in  = frame_ff;

      pg_wr_en   = 1'b0;
      pg_wr_addr = pc_ff[PAW-1:0];
      pg_wr_data = frame_ff[PFN_W-1:0];
      pg_rd_en   = 1'b0;
      pg_rd_addr = pc_dec[PAW-1:0];
      sl_wr_en   = 1'b0;
      sl_wr_addr = sc_ff[SAW-1:0];
      sl_wr_data = {pg_rd_data, sc_ff[CARVE_W-1:0]};
      sl_rd_en   = 1'b0;
      sl_rd_addr = sc_dec[SAW-1:0];

      fin      = 1'b0;
      fin_addr = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_added_in  = rsp_added_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = STAT_OK;
               added_in  = '0;
               state_in  = S_DONE;
               case (req.func)
                  FN_ADD_REGION: begin
                     state_in = S_REGION;
                  end
                  FN_PAGE_ALLOC: begin
                     if (pc_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        pg_rd_en = 1'b1;
                        pc_in    = pc_dec;
                        state_in = S_PAGE_POP;
                     end
                  end
                  FN_PAGE_FREE: begin
                     // a null page is ignored
                     if (req.addr != '0) begin
                        if (pg_full) begin
                           status_in = STAT_FULL;
                        end else begin
                           pg_wr_en   = 1'b1;
                           pg_wr_data = req.addr[ADDR_W-1:PAGE_SHIFT];
                           pc_in      = pc_ff + PCW'(1);
                        end
                     end
                  end
                  FN_SLICE_ALLOC: begin
                     if (sc_ff != '0) begin
                        sl_rd_en = 1'b1;
                        sc_in    = sc_dec;
                        state_in = S_SLICE_POP;
                     end else if (pc_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        pg_rd_en = 1'b1;
                        pc_in    = pc_dec;
                        state_in = S_CARVE;
                     end
                  end
                  FN_SLICE_FREE: begin
                     if (sl_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        sl_wr_en   = 1'b1;
                        sl_wr_data = req.addr[ADDR_W-1:SLICE_SHIFT];
                        sc_in      = sc_ff + SCW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_REGION: begin
            if (win.skip) begin
               status_in = STAT_SKIP;
               state_in  = S_DONE;
            end else begin
               frame_in = win.first;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (frame_ff == win.last) begin
               state_in = S_DONE;
            end else if (pg_full) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else begin
               pg_wr_en = 1'b1;
               pc_in    = pc_ff + PCW'(1);
               frame_in = frame_ff + PFN_EXT_W'(1);
               added_in = added_ff + ADDED_W'(1);
            end
         end
         S_CARVE: begin
            // slice stack is empty here, so the carved slices land at the bottom
            if (sc_ff == CARVE_DONE) begin
               fin      = 1'b1;
               fin_addr = {pg_rd_data, CARVE_DONE[CARVE_W-1:0], SLICE_SHIFT'(0)};
            end else begin
               sl_wr_en = 1'b1;
               sc_in    = sc_ff + SCW'(1);
            end
         end
         S_PAGE_POP: begin
            fin      = 1'b1;
            fin_addr = {pg_rd_data, PAGE_SHIFT'(0)};
         end
         S_SLICE_POP: begin
            fin      = 1'b1;
            fin_addr = {sl_rd_data, SLICE_SHIFT'(0)};
         end
         S_DONE: begin
            fin = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_addr_in   = fin_addr;
         rsp_added_in  = added_ff;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         sc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         cutoff_ff    <= CUTOFF_RESET;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sc_ff        <= sc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cutoff_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      added_ff      <= added_in;
      frame_ff      <= frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_added_ff  <= rsp_added_in;
   end

   assign req.ready       = state_ff == S_IDLE;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.result_addr = rsp_addr_ff;
   assign rsp.pages_added = rsp_added_ff;

endmodule

// File: design/psfl_checker.sv
// port-level assertions for the allocator and their bind to the top level
module psfl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [psfl_pkg::STATUS_W-1:0] rsp_status,
   input logic [psfl_pkg::ADDR_W-1:0]   rsp_result_addr,
   input logic [psfl_pkg::ADDED_W-1:0]  rsp_pages_added
);
   import psfl_pkg::*;

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_result_addr) && $stable(rsp_pages_added))
      else $error("stalled result changed");

   // one item at a time: busy right after an item is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   // only a successful alloc returns an address
   a_addr_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_addr != '0) |-> rsp_status == STAT_OK)
      else $error("address returned with failure status");

   // pages are counted only for a region that was not skipped
   a_added_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pages_added != '0) |->
      (rsp_status == STAT_OK || rsp_status == STAT_FULL) && (rsp_result_addr == '0))
      else $error("pages added with wrong status or address");

endmodule

bind page_slice_free_list_allocator psfl_checker u_psfl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_result_addr (rsp.result_addr),
   .rsp_pages_added (rsp.pages_added)
);

// File: test/tb_page_slice_free_list_allocator.sv
// testbench of the page and slice free-list allocator: random and directed items, self-checking
module tb_page_slice_free_list_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import psfl_pkg::*;

   localparam logic [WIDE_W-1:0] FOUR_GB      = 64'h1_0000_0000;
   localparam logic [WORD_W-1:0] ACPI_ENABLED = WORD_W'(1) << REGION_IGNORE_BIT;
   localparam logic [WORD_W-1:0] ACPI_NONVOL  = WORD_W'(1) << REGION_NONVOL_BIT;
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
   localparam int TOTAL_ITEMS = 1850;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] addr;
      logic [WIDE_W-1:0] base;
      logic [WIDE_W-1:0] len;
      logic [WORD_W-1:0] rtype;
      logic [WORD_W-1:0] acpi;
   } alloc_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   addr;
      logic [ADDED_W-1:0]  added;
   } alloc_reply_type;

   typedef enum {RUN_MIX, RUN_DRAIN, RUN_SLICE} run_mode_type;

   class free_list_tracker;
      logic [ADDR_W-1:0]      cutoff = CUTOFF_RESET;
      logic [PFN_W-1:0]       page_stk [PAGE_CAPACITY_DEF];
      int                     page_cnt = 0;
      logic [SLICE_NUM_W-1:0] slice_stk [SLICE_CAPACITY_DEF];
      int                     slice_cnt = 0;
      alloc_reply_type        expected_replies [$];
      int                     fails = 0;
      int                     checked = 0;
      int                     pages_pushed = 0;
      int                     status_seen [4];

      function bit push_page(logic [PFN_W-1:0] frame);
         if (page_cnt >= PAGE_CAPACITY_DEF) return 1'b0;
         page_stk[page_cnt] = frame;
         page_cnt++;
         return 1'b1;
      endfunction

      function bit push_slice(logic [SLICE_NUM_W-1:0] num);
         if (slice_cnt >= SLICE_CAPACITY_DEF) return 1'b0;
         slice_stk[slice_cnt] = num;
         slice_cnt++;
         return 1'b1;
      endfunction

      function alloc_reply_type add_region(alloc_cmd_type c);
         alloc_reply_type r;
         longint unsigned stop, start, first, last, f;
         r = '{STAT_SKIP, '0, '0};
         if (!c.acpi[REGION_IGNORE_BIT] || c.acpi[REGION_NONVOL_BIT]) return r;
         if (c.rtype != RTYPE_USABLE || c.base >= FOUR_GB) return r;
         // base is below 4 GB here, so the sum cannot wrap
         stop = (c.len >= FOUR_GB) ? FOUR_GB : c.base + c.len;
         if (stop > FOUR_GB) stop = FOUR_GB;
         if (stop < longint'(cutoff)) return r;
         start = (c.base < longint'(cutoff)) ? longint'(cutoff) : c.base;
         first = (start + PAGE_ROUND) >> PAGE_SHIFT;
         last = stop >> PAGE_SHIFT;
         if (last <= first) return r;
         r.status = STAT_OK;
         for (f = first; f < last; f++) begin
            if (!push_page(f[PFN_W-1:0])) begin
               r.status = STAT_FULL;
               return r;
            end
            r.added = r.added + 1'b1;
         end
         return r;
      endfunction

      function void note_request(alloc_cmd_type c);
         alloc_reply_type  r;
         logic [PFN_W-1:0] frame;
         r = '{STAT_OK, '0, '0};
         case (c.func)
            FN_ADD_REGION: r = add_region(c);
            FN_PAGE_ALLOC: begin
               if (page_cnt == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  page_cnt--;
                  r.addr = ADDR_W'(page_stk[page_cnt]) << PAGE_SHIFT;
               end
            end
            FN_PAGE_FREE: begin
               if (c.addr != '0 && !push_page(c.addr[ADDR_W-1:PAGE_SHIFT]))
                  r.status = STAT_FULL;
            end
            FN_SLICE_ALLOC: begin
               if (slice_cnt == 0 && page_cnt == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  // no free slice: carve the top page into four
                  if (slice_cnt == 0) begin
                     page_cnt--;
                     frame = page_stk[page_cnt];
                     for (int i = 0; i < 4; i++)
                        void'(push_slice({frame, CARVE_W'(i)}));
                  end
                  slice_cnt--;
                  r.addr = ADDR_W'(slice_stk[slice_cnt]) << SLICE_SHIFT;
               end
            end
            FN_SLICE_FREE: begin
               if (!push_slice(c.addr[ADDR_W-1:SLICE_SHIFT])) r.status = STAT_FULL;
            end
            default: ;
         endcase
         pages_pushed += r.added;
         expected_replies.push_back(r);
      endfunction

      task report(string msg);
         fails++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_reply(alloc_reply_type got);
         alloc_reply_type e;
         if (expected_replies.size() == 0) begin
            report($sformatf("unexpected item status %0d addr %h added %0d",
                             got.status, got.addr, got.added));
            return;
         end
         e = expected_replies.pop_front();
         checked++;
         status_seen[e.status]++;
         if (got.status !== e.status)
            report($sformatf("status %0d, expected %0d", got.status, e.status));
         if (got.addr !== e.addr)
            report($sformatf("result_addr %h, expected %h", got.addr, e.addr));
         if (got.added !== e.added)
            report($sformatf("pages_added %0d, expected %0d", got.added, e.added));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [ADDR_W-1:0] csr_wr_data;

   psfl_req_if req ();
   psfl_rsp_if rsp ();

   free_list_tracker tracker;
   int sent = 0;
   int send_idle_pct = 13;
   int recv_idle_pct = 51;
   int hold_asked = 0;

   page_slice_free_list_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("page_slice_free_list_allocator verification failed");
      $finish;
   end

   // receiver: random back-pressure plus one long hold on request
   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         tracker.note_request(alloc_cmd_type'{req.func, req.addr, req.region_base,
                                              req.region_length, req.region_type,
                                              req.region_acpi});
      if (!reset && rsp.valid && rsp.ready)
         tracker.check_reply(alloc_reply_type'{rsp.status, rsp.result_addr,
                                               rsp.pages_added});
   end

   function automatic alloc_cmd_type mk(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                        logic [WIDE_W-1:0] b, logic [WIDE_W-1:0] l,
                                        logic [WORD_W-1:0] t, logic [WORD_W-1:0] ac);
      alloc_cmd_type c;
      c = '{f, a, b, l, t, ac};
      return c;
   endfunction

   task automatic send_item(alloc_cmd_type c);
      if (sent < TOTAL_ITEMS / 3) begin
         send_idle_pct = 13;
         recv_idle_pct = 51;
      end else if (sent < 2 * TOTAL_ITEMS / 3) begin
         send_idle_pct = 51;
         recv_idle_pct = 13;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= c.func;
      req.addr <= c.addr;
      req.region_base <= c.base;
      req.region_length <= c.len;
      req.region_type <= c.rtype;
      req.region_acpi <= c.acpi;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   // one edge first so the item taken at the last edge is already noted
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_cutoff(logic [ADDR_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.cutoff = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic alloc_cmd_type rand_region();
      alloc_cmd_type c;
      int pick;
      c.func = FN_ADD_REGION;
      c.addr = $urandom;
      c.base = {32'h0, 32'($urandom)};
      c.len = 64'($urandom_range(64)) * 4096 + 64'($urandom_range(4095));
      c.rtype = RTYPE_USABLE;
      c.acpi = $urandom_range(1) ? ACPI_ENABLED : (($urandom & ~ACPI_NONVOL) | ACPI_ENABLED);
      pick = $urandom_range(99);
      if (pick < 4) c.len = 64'($urandom_range(1100)) << PAGE_SHIFT;
      if (pick >= 85) begin
         case (pick % 5)
            0: c.acpi[REGION_IGNORE_BIT] = 1'b0;
            1: c.acpi[REGION_NONVOL_BIT] = 1'b1;
            2: c.rtype = $urandom;
            3: c.base = {32'($urandom), 32'($urandom)};
            default: begin
               c.len = {32'($urandom), 32'($urandom)};
               if ($urandom_range(1)) begin
                  c.base = {32'($urandom), 32'($urandom)};
                  c.rtype = $urandom;
                  c.acpi = $urandom;
               end
            end
         endcase
      end
      return c;
   endfunction

   function automatic alloc_cmd_type rand_item(run_mode_type mode);
      alloc_cmd_type c;
      int w;
      c = rand_region();
      w = $urandom_range(99);
      case (mode)
         RUN_MIX: begin
            if (w < 20) c.func = FN_ADD_REGION;
            else if (w < 40) c.func = FN_PAGE_ALLOC;
            else if (w < 58) c.func = FN_PAGE_FREE;
            else if (w < 75) c.func = FN_SLICE_ALLOC;
            else if (w < 95) c.func = FN_SLICE_FREE;
            else c.func = FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
         end
         RUN_DRAIN: begin
            if (w < 75) c.func = FN_PAGE_ALLOC;
            else if (w < 90) c.func = FN_SLICE_ALLOC;
            else c.func = FN_ADD_REGION;
         end
         default: begin
            if (w < 45) c.func = FN_SLICE_ALLOC;
            else if (w < 90) c.func = FN_SLICE_FREE;
            else if (w < 95) c.func = FN_PAGE_ALLOC;
            else c.func = FN_PAGE_FREE;
         end
      endcase
      if ($urandom_range(19) == 0) c.addr = '0;
      return c;
   endfunction

   task automatic random_runs(int n);
      int stop_at;
      int w;
      int run_len;
      run_mode_type mode;
      stop_at = sent + n;
      while (sent < stop_at) begin
         w = $urandom_range(99);
         mode = (w < 50) ? RUN_MIX : (w < 75) ? RUN_DRAIN : RUN_SLICE;
         run_len = $urandom_range(60, 15);
         for (int i = 0; i < run_len && sent < stop_at; i++)
            send_item(rand_item(mode));
      end
   endtask

   // enough slice frees to overflow the slice stack
   task automatic slice_flood();
      alloc_cmd_type c;
      while (tracker.slice_cnt < SLICE_CAPACITY_DEF) begin
         c = rand_region();
         c.func = FN_SLICE_FREE;
         send_item(c);
      end
      repeat (12) begin
         c = rand_region();
         c.func = FN_SLICE_FREE;
         send_item(c);
      end
   endtask

   task automatic run_directed();
      send_item(mk(FN_PAGE_ALLOC, '0, '0, '0, '0, '0));
      send_item(mk(FN_SLICE_ALLOC, '0, '0, '0, '0, '0));
      send_item(mk(FN_UNUSED_LO, '1, '1, '1, '1, '1));
      send_item(mk(FN_UNUSED_HI, '0, '0, '0, '0, '0));
      // rejected descriptors
      send_item(mk(FN_ADD_REGION, '0, 64'h20_0000, 64'h10_0000, RTYPE_USABLE, ~ACPI_ENABLED));
      send_item(mk(FN_ADD_REGION, '0, 64'h20_0000, 64'h10_0000, RTYPE_USABLE,
                   ACPI_ENABLED | ACPI_NONVOL));
      send_item(mk(FN_ADD_REGION, '0, 64'h20_0000, 64'h10_0000, RTYPE_USABLE + 1'b1,
                   ACPI_ENABLED));
      send_item(mk(FN_ADD_REGION, '0, FOUR_GB, 64'h10_0000, RTYPE_USABLE, ACPI_ENABLED));
      send_item(mk(FN_ADD_REGION, '0, '1, 64'h1000, RTYPE_USABLE, ACPI_ENABLED));
      // entirely below the cutoff, then no whole page left
      send_item(mk(FN_ADD_REGION, '0, '0, 64'h8_0000, RTYPE_USABLE, ACPI_ENABLED));
      send_item(mk(FN_ADD_REGION, '0, 64'h20_0001, 64'h1000, RTYPE_USABLE, ACPI_ENABLED));
      // clipped to the cutoff, unaligned start, clipped at 4 GB
      send_item(mk(FN_ADD_REGION, '0, 64'hF_F000, 64'h3000, RTYPE_USABLE, ACPI_ENABLED));
      send_item(mk(FN_ADD_REGION, '0, 64'h10_0800, 64'h5000, RTYPE_USABLE, ACPI_ENABLED));
      send_item(mk(FN_ADD_REGION, '0, 64'hFFFF_E000, '1, RTYPE_USABLE, ACPI_ENABLED));
      send_item(mk(FN_ADD_REGION, '0, 64'hFFFF_C000, 64'hFFFF_FFFF, RTYPE_USABLE,
                   ACPI_ENABLED));
      send_item(mk(FN_PAGE_ALLOC, '0, '0, '0, '0, '0));
      send_item(mk(FN_PAGE_FREE, '0, '0, '0, '0, '0));
      send_item(mk(FN_PAGE_FREE, '1, '0, '0, '0, '0));
      send_item(mk(FN_SLICE_ALLOC, '0, '0, '0, '0, '0));
      send_item(mk(FN_SLICE_ALLOC, '0, '0, '0, '0, '0));
      send_item(mk(FN_SLICE_FREE, '0, '0, '0, '0, '0));
      send_item(mk(FN_SLICE_FREE, '1, '0, '0, '0, '0));
      // overfill the page stack, then push onto it while full
      send_item(mk(FN_ADD_REGION, '0, 64'h1000_0000, 64'h50_0000, RTYPE_USABLE,
                   ACPI_ENABLED));
      send_item(mk(FN_PAGE_FREE, 32'h1234_5000, '0, '0, '0, '0));
      send_item(mk(FN_ADD_REGION, '0, 64'h2000_0000, 64'h2000, RTYPE_USABLE, ACPI_ENABLED));
   endtask

   initial begin
      tracker = new;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req.valid = 1'b0;
      req.func = '0;
      req.addr = '0;
      req.region_base = '0;
      req.region_length = '0;
      req.region_type = '0;
      req.region_acpi = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      write_cutoff('0);
      random_runs(250);
      write_cutoff('1);
      random_runs(100);
      write_cutoff(32'h8000_0000);
      hold_asked++;
      slice_flood();
      random_runs(150);
      write_cutoff($urandom);
      random_runs(150);
      write_cutoff(CUTOFF_RESET);
      if (sent < TOTAL_ITEMS) random_runs(TOTAL_ITEMS - sent);

      drain();
      repeat (40) @(posedge clock);
      $display("sent %0d items, checked %0d results, %0d pages added by regions",
               sent, tracker.checked, tracker.pages_pushed);
      $display("status counts: ok %0d, empty %0d, skipped %0d, full %0d; %0d mismatches",
               tracker.status_seen[STAT_OK], tracker.status_seen[STAT_EMPTY],
               tracker.status_seen[STAT_SKIP], tracker.status_seen[STAT_FULL], tracker.fails);
      if (tracker.fails == 0)
         $display("page_slice_free_list_allocator verification clean");
      else
         $display("page_slice_free_list_allocator verification failed");
      $finish;
   end

endmodule

// File: filelist.f
design/psfl_pkg.sv
design/psfl_if.sv
design/psfl_ram.sv
design/psfl_region.sv
design/page_slice_free_list_allocator.sv
design/psfl_checker.sv
test/tb_page_slice_free_list_allocator.sv
